/* design/bsg_pkg.sv */
`default_nettype none

package bsg_pkg;

  // Default coordinate width (signed Q16.16).
  localparam int unsigned CoordWidthDef = 32;

  // Configuration register indexes.
  localparam logic [1:0] CfgCenterX = 2'd0;
  localparam logic [1:0] CfgCenterY = 2'd1;
  localparam logic [1:0] CfgCenterZ = 2'd2;
  localparam logic [1:0] CfgRadius  = 2'd3;

  // Axis codes.
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisZ = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SQ_LD,
    S_SQ_RUN,
    S_SQRT,
    S_CMP,
    S_PROD_LD,
    S_PROD_RUN,
    S_DIV_LD,
    S_DIV_RUN,
    S_UPD,
    S_RAD,
    S_FIN
  } state_e;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    state_e     st;
    logic [1:0] axis;
    logic       last;
  } ctl_t;

endpackage

`default_nettype wire

/* design/bsg_addsub.sv */
`default_nettype none

// Shared adder/subtractor used by the datapath for all but the point-to-center differences.
module bsg_addsub #(
  parameter int unsigned Width = 66
) (
  input  wire logic [Width-1:0] a_i,
  input  wire logic [Width-1:0] b_i,
  input  wire logic             sub_i,
  output logic      [Width-1:0] sum_o,
  output logic                  carry_o
);

  logic [Width:0] full;

  // With sub_i set, carry_o high means a_i >= b_i.
  assign full    = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {{Width{1'b0}}, sub_i};
  assign sum_o   = full[Width-1:0];
  assign carry_o = full[Width];

endmodule

`default_nettype wire

/* design/bsg_seq.sv */
`default_nettype none

// Sequencer: walks one item through squares, square root, compare and, if the
// sphere grows, per-axis product, division and center update, then radius update.
module bsg_seq #(
  parameter int unsigned Steps = 33
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic         grow_i,
  input  wire logic         out_free_i,
  output bsg_pkg::ctl_t     ctl_o
);

  localparam int unsigned CntW = $clog2(Steps);

  bsg_pkg::state_e st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      axis_q, axis_d;
  logic            last;

  assign last = (cnt_q == CntW'(Steps - 1));

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      bsg_pkg::S_IDLE:     if (start_i) st_d = bsg_pkg::S_DIFF;
      bsg_pkg::S_DIFF:     st_d = bsg_pkg::S_SQ_LD;
      bsg_pkg::S_SQ_LD:    st_d = bsg_pkg::S_SQ_RUN;
      bsg_pkg::S_SQ_RUN: begin
        if (last) st_d = (axis_q == bsg_pkg::AxisZ) ? bsg_pkg::S_SQRT : bsg_pkg::S_SQ_LD;
      end
      bsg_pkg::S_SQRT:     if (last) st_d = bsg_pkg::S_CMP;
      bsg_pkg::S_CMP:      st_d = grow_i ? bsg_pkg::S_PROD_LD : bsg_pkg::S_FIN;
      bsg_pkg::S_PROD_LD:  st_d = bsg_pkg::S_PROD_RUN;
      bsg_pkg::S_PROD_RUN: if (last) st_d = bsg_pkg::S_DIV_LD;
      bsg_pkg::S_DIV_LD:   st_d = bsg_pkg::S_DIV_RUN;
      bsg_pkg::S_DIV_RUN:  if (last) st_d = bsg_pkg::S_UPD;
      bsg_pkg::S_UPD: begin
        st_d = (axis_q == bsg_pkg::AxisZ) ? bsg_pkg::S_RAD : bsg_pkg::S_PROD_LD;
      end
      bsg_pkg::S_RAD:      st_d = bsg_pkg::S_FIN;
      bsg_pkg::S_FIN:      if (out_free_i) st_d = bsg_pkg::S_IDLE;
      default:             st_d = bsg_pkg::S_IDLE;
    endcase
  end

  // Step counter and axis select.
  always_comb begin
    cnt_d  = (st_d == st_q) ? cnt_q + 1'b1 : '0;
    axis_d = axis_q;
    unique case (st_q)
      bsg_pkg::S_DIFF, bsg_pkg::S_CMP: axis_d = bsg_pkg::AxisX;
      bsg_pkg::S_SQ_RUN: if (last && axis_q != bsg_pkg::AxisZ) axis_d = axis_q + 1'b1;
      bsg_pkg::S_UPD:    if (axis_q != bsg_pkg::AxisZ) axis_d = axis_q + 1'b1;
      default:           axis_d = axis_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= bsg_pkg::S_IDLE;
      cnt_q  <= '0;
      axis_q <= bsg_pkg::AxisX;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      axis_q <= axis_d;
    end
  end

  assign ctl_o = '{st: st_q, axis: axis_q, last: last};

endmodule

`default_nettype wire

/* design/bounding_sphere_grow_top.sv */
`default_nettype none

// Channel  | Dir | Handshake                | Payload (low bit up)
// s_axis   | in  | s_axis_tvalid/tready     | tdata: point_x, point_y, point_z; tuser: restart
// m_axis   | out | m_axis_tvalid/tready     | tdata: center_out_x/y/z, radius_out; tuser: grew
// cfg      | in  | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// One item at a time, all arithmetic but the point-to-center differences through one
// shared adder/subtractor. An item goes through three bit-serial squares and the
// bit-serial square root, and, when the point grows the sphere, through three
// bit-serial products and three divisions.
// rst_ni clears the sphere and the configuration registers to zero.
// A stalled result waits in the output register; the next item is taken meanwhile.
module bounding_sphere_grow_top #(
  parameter int unsigned CoordWidth = bsg_pkg::CoordWidthDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // point_x, point_y, point_z
  input  wire logic [((3*CoordWidth+7)/8)*8-1:0]    s_axis_tdata_i,
  // restart
  input  wire logic                                 s_axis_tuser_i,
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // center_out_x, center_out_y, center_out_z, radius_out
  output logic      [((4*CoordWidth-1+7)/8)*8-1:0]  m_axis_tdata_o,
  // grew
  output logic                                      m_axis_tuser_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [1:0]                           cfg_index_i,
  input  wire logic [CoordWidth-1:0]                cfg_data_i
);

  localparam int unsigned CW  = CoordWidth;
  localparam int unsigned RW  = CW - 1;
  localparam int unsigned N   = CW + 1;
  localparam int unsigned AW  = 2 * N;
  localparam int unsigned OW  = ((4*CW-1+7)/8)*8;

  bsg_pkg::ctl_t ctl;

  // Configuration registers.
  logic [CW-1:0] cfg_c_q [3];
  logic [RW-1:0] cfg_r_q;

  // Sphere and working registers.
  logic [CW-1:0] c_q [3], c_d [3];
  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] p_q [3], p_d [3];
  logic [N-1:0]  mag_q [3], mag_d [3];
  logic [2:0]    neg_q, neg_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [AW-1:0] mc_q, mc_d;
  logic [N-1:0]  mp_q, mp_d;
  logic [N:0]    rem_q, rem_d;
  logic [N-1:0]  root_q, root_d;
  logic [N-1:0]  h_q, h_d;
  logic [N-1:0]  quo_q, quo_d;
  logic          grew_q, grew_d;

  // Output register.
  logic          ov_q;
  logic [OW-1:0] od_q;
  logic          og_q;

  logic          accept, out_free, grow;
  logic [AW-1:0] ua, ub, usum;
  logic          usub, ucarry;
  logic [N+2:0]  sq_rem_t;
  logic [N+1:0]  sq_trial;
  logic [N:0]    dv_rem_t;
  logic [N-1:0]  diff [3];

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (ctl.st == bsg_pkg::S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign sq_rem_t        = {rem_q, acc_q[AW-1 -: 2]};
  assign sq_trial        = {root_q, 2'b01};
  assign dv_rem_t        = {rem_q[N-1:0], acc_q[N-1]};
  assign grow            = ucarry && (usum != '0);

  bsg_seq #(.Steps(N)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .grow_i     (grow),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  bsg_addsub #(.Width(AW)) u_alu (
    .a_i     (ua),
    .b_i     (ub),
    .sub_i   (usub),
    .sum_o   (usum),
    .carry_o (ucarry)
  );

  // Per-axis differences between point and center.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {p_q[i][CW-1], p_q[i]} - {c_q[i][CW-1], c_q[i]};
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    ua   = '0;
    ub   = '0;
    usub = 1'b0;
    unique case (ctl.st)
      bsg_pkg::S_SQ_RUN, bsg_pkg::S_PROD_RUN: begin
        ua = acc_q;
        ub = mc_q;
      end
      bsg_pkg::S_SQRT: begin
        ua   = AW'(sq_rem_t);
        ub   = AW'(sq_trial);
        usub = 1'b1;
      end
      bsg_pkg::S_DIV_RUN: begin
        ua   = AW'(dv_rem_t);
        ub   = AW'(root_q);
        usub = 1'b1;
      end
      bsg_pkg::S_CMP: begin
        ua   = AW'(root_q);
        ub   = AW'(r_q);
        usub = 1'b1;
      end
      bsg_pkg::S_UPD: begin
        ua   = {{(AW-CW){c_q[ctl.axis][CW-1]}}, c_q[ctl.axis]};
        ub   = AW'(quo_q);
        usub = neg_q[ctl.axis];
      end
      bsg_pkg::S_RAD: begin
        ua = AW'(r_q);
        ub = AW'(h_q);
      end
      default: begin
        ua   = '0;
        ub   = '0;
        usub = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    c_d    = c_q;
    r_d    = r_q;
    p_d    = p_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    rem_d  = rem_q;
    root_d = root_q;
    h_d    = h_q;
    quo_d  = quo_q;
    grew_d = grew_q;
    unique case (ctl.st)
      bsg_pkg::S_IDLE: begin
        if (accept) begin
          p_d[0] = s_axis_tdata_i[CW-1:0];
          p_d[1] = s_axis_tdata_i[2*CW-1:CW];
          p_d[2] = s_axis_tdata_i[3*CW-1:2*CW];
          grew_d = 1'b0;
          if (s_axis_tuser_i) begin
            c_d = cfg_c_q;
            r_d = cfg_r_q;
          end
        end
      end
      bsg_pkg::S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          neg_d[i] = diff[i][N-1];
          mag_d[i] = diff[i][N-1] ? (~diff[i] + 1'b1) : diff[i];
        end
        acc_d  = '0;
        rem_d  = '0;
        root_d = '0;
      end
      bsg_pkg::S_SQ_LD: begin
        mc_d = AW'(mag_q[ctl.axis]);
        mp_d = mag_q[ctl.axis];
      end
      bsg_pkg::S_SQ_RUN, bsg_pkg::S_PROD_RUN: begin
        if (mp_q[0]) acc_d = usum;
        mc_d = {mc_q[AW-2:0], 1'b0};
        mp_d = {1'b0, mp_q[N-1:1]};
      end
      bsg_pkg::S_SQRT: begin
        // One root bit per cycle, two radicand bits shifted in.
        if (ucarry) begin
          rem_d  = usum[N:0];
          root_d = {root_q[N-2:0], 1'b1};
        end else begin
          rem_d  = sq_rem_t[N:0];
          root_d = {root_q[N-2:0], 1'b0};
        end
        acc_d = {acc_q[AW-3:0], 2'b00};
      end
      bsg_pkg::S_CMP: begin
        grew_d = grow;
        h_d    = {1'b0, usum[N-1:1]};
      end
      bsg_pkg::S_PROD_LD: begin
        mc_d  = AW'(mag_q[ctl.axis]);
        mp_d  = h_q;
        acc_d = '0;
      end
      bsg_pkg::S_DIV_LD: begin
        // The quotient fits in N bits, so the upper half is below the divisor.
        rem_d = {1'b0, acc_q[AW-1:N]};
        quo_d = '0;
      end
      bsg_pkg::S_DIV_RUN: begin
        rem_d = ucarry ? {1'b0, usum[N-1:0]} : {1'b0, dv_rem_t[N-1:0]};
        quo_d = {quo_q[N-2:0], ucarry};
        acc_d = {acc_q[AW-2:0], 1'b0};
      end
      bsg_pkg::S_UPD: begin
        // Saturate the moved center to the signed coordinate range.
        if (!usum[AW-1] && (|usum[AW-2:CW-1])) begin
          c_d[ctl.axis] = {1'b0, {(CW-1){1'b1}}};
        end else if (usum[AW-1] && !(&usum[AW-2:CW-1])) begin
          c_d[ctl.axis] = {1'b1, {(CW-1){1'b0}}};
        end else begin
          c_d[ctl.axis] = usum[CW-1:0];
        end
      end
      bsg_pkg::S_RAD: begin
        r_d = (|usum[AW-1:RW]) ? {RW{1'b1}} : usum[RW-1:0];
      end
      default: begin
        grew_d = grew_q;
      end
    endcase
  end

  // Sphere and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i]     <= '0;
        cfg_c_q[i] <= '0;
      end
      r_q     <= '0;
      cfg_r_q <= '0;
    end else begin
      c_q <= c_d;
      r_q <= r_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          bsg_pkg::CfgCenterX: cfg_c_q[0] <= cfg_data_i;
          bsg_pkg::CfgCenterY: cfg_c_q[1] <= cfg_data_i;
          bsg_pkg::CfgCenterZ: cfg_c_q[2] <= cfg_data_i;
          bsg_pkg::CfgRadius:  cfg_r_q    <= cfg_data_i[RW-1:0];
          default:             cfg_r_q    <= cfg_r_q;
        endcase
      end
    end
  end

  // Working registers need no reset.
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    mc_q   <= mc_d;
    mp_q   <= mp_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    h_q    <= h_d;
    quo_q  <= quo_d;
    grew_q <= grew_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ctl.st == bsg_pkg::S_FIN && out_free) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.st == bsg_pkg::S_FIN && out_free) begin
      od_q <= OW'({r_q, c_q[2], c_q[1], c_q[0]});
      og_q <= grew_q;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tuser_o  = og_q;

endmodule

`default_nettype wire

/* design/bsg_checker.sv */
`default_nettype none

module bsg_checker #(
  parameter int unsigned CoordWidth = bsg_pkg::CoordWidthDef
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid_i,
  input wire logic                                s_axis_tready_o,
  input wire logic [((3*CoordWidth+7)/8)*8-1:0]   s_axis_tdata_i,
  input wire logic                                s_axis_tuser_i,
  input wire logic                                m_axis_tvalid_o,
  input wire logic                                m_axis_tready_i,
  input wire logic [((4*CoordWidth-1+7)/8)*8-1:0] m_axis_tdata_o,
  input wire logic                                m_axis_tuser_o,
  input wire logic                                cfg_valid_i,
  input wire logic                                cfg_ready_o,
  input wire logic [1:0]                          cfg_index_i,
  input wire logic [CoordWidth-1:0]               cfg_data_i
);

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  // A result never shows up right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared one cycle after acceptance");

  // A new result ends a busy period.
  a_result_ends_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o) && s_axis_tready_o)
    else $error("result not tied to the end of an item");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind bounding_sphere_grow_top bsg_checker #(.CoordWidth(CoordWidth)) u_bsg_checker (.*);

`default_nettype wire
